/* rtl/fvdi_pkg.sv */
// ----------------------------------------------------------------------------
// fvdi_pkg: shared constants and types
// Table geometry, attribute layout and tolerance defaults for the fuzzy
// vertex deduplicating indexer.
// ----------------------------------------------------------------------------
package fvdi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ATTR_COUNT  = 8;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int TOL_W       = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

  // Attribute slots inside one packed vertex word.
  localparam int ATTR_POS_X  = 0;
  localparam int ATTR_POS_Y  = 1;
  localparam int ATTR_POS_Z  = 2;
  localparam int ATTR_NORM_X = 3;
  localparam int ATTR_NORM_Y = 4;
  localparam int ATTR_NORM_Z = 5;
  localparam int ATTR_TEX_U  = 6;
  localparam int ATTR_TEX_V  = 7;

  typedef logic [ATTR_COUNT-1:0][VALUE_WIDTH-1:0] vtx_t;

endpackage

/* rtl/fvdi_match.sv */
// ----------------------------------------------------------------------------
// fvdi_match: per-attribute closeness compare
// Flags a hit when all eight attributes of the stored entry differ from the
// incoming vertex by strictly less than the tolerance.
// ----------------------------------------------------------------------------
module fvdi_match (
  input  fvdi_pkg::vtx_t                  vtx,
  input  fvdi_pkg::vtx_t                  entry,
  input  logic [fvdi_pkg::TOL_W-1:0]      tol,
  output logic                            hit
);

  always_comb begin : p_cmp
    logic [fvdi_pkg::VALUE_WIDTH:0] a_ext;
    logic [fvdi_pkg::VALUE_WIDTH:0] b_ext;
    logic [fvdi_pkg::VALUE_WIDTH:0] diff;
    logic [fvdi_pkg::VALUE_WIDTH:0] mag;
    hit = 1'b1;
    for (int k = 0; k < fvdi_pkg::ATTR_COUNT; k++) begin
      a_ext = {vtx[k][fvdi_pkg::VALUE_WIDTH-1], vtx[k]};
      b_ext = {entry[k][fvdi_pkg::VALUE_WIDTH-1], entry[k]};
      diff  = a_ext - b_ext;
      // The difference of two sign-extended values never reaches the
      // negative limit of the wider word, so negation is exact.
      mag   = diff[fvdi_pkg::VALUE_WIDTH] ? (~diff + 1'b1) : diff;
      if (mag >= (fvdi_pkg::VALUE_WIDTH + 1)'(tol)) begin
        hit = 1'b0;
      end
    end
  end

endmodule

/* rtl/fuzzy_vertex_dedup_indexer.sv */
// ----------------------------------------------------------------------------
// fuzzy_vertex_dedup_indexer: vertex indexing with tolerance match
// Linear search over a table of unique vertices held in one synchronous RAM;
// returns the index of the first close entry, else appends the vertex if room is left.
// ----------------------------------------------------------------------------
// One item is handled at a time. The search reads one stored entry per cycle
// and compares it with the item in the cycle after its address went out. A
// match ends the search at the first close entry; a miss reads every stored
// entry, or none when the table is empty. The search time is set by the
// single read port of the vertex RAM, which delivers one stored entry per
// cycle to the compare unit. While the previous result stays stalled in the
// output register, a finished search waits in the finish state. A new item
// is taken as soon as the previous result sits in the output register, even
// while that result is still stalled. The tolerance register may be written
// at any time the block is idle; it applies to all following items.
// ----------------------------------------------------------------------------
module fuzzy_vertex_dedup_indexer (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_we,
  input  logic [fvdi_pkg::TOL_W-1:0]       cfg_wdata,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_start_of_mesh,
  input  logic signed [31:0]               in_pos_x,
  input  logic signed [31:0]               in_pos_y,
  input  logic signed [31:0]               in_pos_z,
  input  logic signed [31:0]               in_norm_x,
  input  logic signed [31:0]               in_norm_y,
  input  logic signed [31:0]               in_norm_z,
  input  logic signed [31:0]               in_tex_u,
  input  logic signed [31:0]               in_tex_v,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [9:0]                       out_match_index,
  output logic                             out_is_new,
  output logic                             out_table_full,
  output logic [10:0]                      out_unique_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t                           state_r;
  logic [fvdi_pkg::CNT_W-1:0]       cnt_r;       // entries in the table
  logic [fvdi_pkg::CNT_W-1:0]       iss_r;       // next address to read
  logic [fvdi_pkg::ADDR_W-1:0]      chk_r;       // address of the data in q_r
  logic                             q_vld_r;     // q_r holds a fresh entry
  logic                             found_r;
  logic [fvdi_pkg::ADDR_W-1:0]      hit_idx_r;
  logic [fvdi_pkg::TOL_W-1:0]       tol_r;
  fvdi_pkg::vtx_t                   vtx_r;
  fvdi_pkg::vtx_t                   q_r;

  logic                             out_valid_r;
  logic [9:0]                       out_match_index_r;
  logic                             out_is_new_r;
  logic                             out_table_full_r;
  logic [10:0]                      out_unique_count_r;

  fvdi_pkg::vtx_t                   in_vtx;
  logic                             hit;
  logic                             rd_en;
  logic                             wr_en;
  logic                             out_free;
  logic                             has_room;

  // The vertex RAM: all eight attributes of one entry share one word.
  fvdi_pkg::vtx_t                   mem [fvdi_pkg::TABLE_DEPTH];

  always_comb begin
    in_vtx                        = '0;
    in_vtx[fvdi_pkg::ATTR_POS_X]  = in_pos_x;
    in_vtx[fvdi_pkg::ATTR_POS_Y]  = in_pos_y;
    in_vtx[fvdi_pkg::ATTR_POS_Z]  = in_pos_z;
    in_vtx[fvdi_pkg::ATTR_NORM_X] = in_norm_x;
    in_vtx[fvdi_pkg::ATTR_NORM_Y] = in_norm_y;
    in_vtx[fvdi_pkg::ATTR_NORM_Z] = in_norm_z;
    in_vtx[fvdi_pkg::ATTR_TEX_U]  = in_tex_u;
    in_vtx[fvdi_pkg::ATTR_TEX_V]  = in_tex_v;
  end

  // The search reads entries below the count only; the append write happens
  // in the finish state, after all reads of this item and before any read of
  // the next one, so a read and a write never meet on one entry.
  assign rd_en    = (state_r == ST_SEARCH) && (iss_r < cnt_r);
  assign has_room = cnt_r < fvdi_pkg::CNT_W'(fvdi_pkg::TABLE_DEPTH);
  assign out_free = !out_valid_r || !out_stall;
  assign wr_en    = (state_r == ST_FINISH) && out_free && !found_r && has_room;

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[fvdi_pkg::ADDR_W-1:0]] <= vtx_r;
    end
    if (rd_en) begin
      q_r <= mem[iss_r[fvdi_pkg::ADDR_W-1:0]];
    end
  end

  fvdi_match u_match (
    .vtx   (vtx_r),
    .entry (q_r),
    .tol   (tol_r),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      iss_r       <= '0;
      q_vld_r     <= 1'b0;
      found_r     <= 1'b0;
      tol_r       <= fvdi_pkg::TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      // The output register loads when the search is done and the register
      // is free; otherwise it empties once its item has been taken.
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            vtx_r   <= in_vtx;
            iss_r   <= '0;
            q_vld_r <= 1'b0;
            found_r <= 1'b0;
            if (in_start_of_mesh) begin
              cnt_r <= '0;
            end
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // Reads are issued back to back; each entry is compared in the cycle
          // after its address went out.
          q_vld_r <= rd_en;
          chk_r   <= iss_r[fvdi_pkg::ADDR_W-1:0];
          if (rd_en) begin
            iss_r <= iss_r + 1'b1;
          end
          if (q_vld_r && hit) begin
            found_r   <= 1'b1;
            hit_idx_r <= chk_r;
            state_r   <= ST_FINISH;
          end else if (!q_vld_r && (iss_r == cnt_r)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (found_r) begin
              out_match_index_r  <= hit_idx_r;
              out_is_new_r       <= 1'b0;
              out_table_full_r   <= 1'b0;
              out_unique_count_r <= cnt_r;
            end else if (has_room) begin
              out_match_index_r  <= cnt_r[fvdi_pkg::ADDR_W-1:0];
              out_is_new_r       <= 1'b1;
              out_table_full_r   <= 1'b0;
              out_unique_count_r <= cnt_r + 1'b1;
              cnt_r              <= cnt_r + 1'b1;
            end else begin
              // No match and no room: nothing is stored.
              out_match_index_r  <= '0;
              out_is_new_r       <= 1'b0;
              out_table_full_r   <= 1'b1;
              out_unique_count_r <= cnt_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_index  = out_match_index_r;
  assign out_is_new       = out_is_new_r;
  assign out_table_full   = out_table_full_r;
  assign out_unique_count = out_unique_count_r;

  // The entry count never exceeds the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fvdi_pkg::CNT_W'(fvdi_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // An append always grows the count by exactly one.
  a_append_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("append did not advance the entry count");

  // A new entry and a full table are never reported together.
  a_new_vs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_table_full))
    else $error("result flags both new and full");

  // A full-table result reports index zero and a full count.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      ((out_match_index == '0) &&
       (out_unique_count == 11'(fvdi_pkg::TABLE_DEPTH))))
    else $error("full-table result carries wrong index or count");

endmodule

/* bench/fvdi_dedup_checker.sv */
// ----------------------------------------------------------------------------
// fvdi_dedup_checker: result checker for the vertex dedup indexer
// Watches the configuration port and both item channels, keeps its own copy
// of the unique-vertex table and tolerance, and compares each result with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module fvdi_dedup_checker
  import fvdi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [TOL_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_start_of_mesh,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic signed [31:0]   in_norm_x,
  input  logic signed [31:0]   in_norm_y,
  input  logic signed [31:0]   in_norm_z,
  input  logic signed [31:0]   in_tex_u,
  input  logic signed [31:0]   in_tex_v,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [9:0]           out_match_index,
  input  logic                 out_is_new,
  input  logic                 out_table_full,
  input  logic [10:0]          out_unique_count,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [ADDR_W-1:0] index;
    logic              is_new;
    logic              full;
    logic [CNT_W-1:0]  count;
  } dedup_result_t;

  vtx_t               uniq_vtx [TABLE_DEPTH];
  int                 uniq_count;
  logic [TOL_W-1:0]   tolerance;
  dedup_result_t      awaited_indices [$];
  int                 errors;

  // Every attribute must lie strictly closer than the tolerance.
  function automatic bit close_enough(vtx_t a, vtx_t b);
    longint d;
    for (int k = 0; k < ATTR_COUNT; k++) begin
      d = longint'($signed(a[k])) - longint'($signed(b[k]));
      if (d < 0) d = -d;
      if (d >= longint'(tolerance)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic dedup_result_t index_vertex(logic start, vtx_t v);
    dedup_result_t r;
    bit            hit;
    int            hit_at;
    r = '0;
    hit = 1'b0;
    hit_at = 0;
    if (start) uniq_count = 0;
    for (int i = 0; i < uniq_count && !hit; i++) begin
      if (close_enough(uniq_vtx[i], v)) begin
        hit = 1'b1;
        hit_at = i;
      end
    end
    if (hit) begin
      r.index = ADDR_W'(hit_at);
    end else if (uniq_count < TABLE_DEPTH) begin
      uniq_vtx[uniq_count] = v;
      r.index = ADDR_W'(uniq_count);
      r.is_new = 1'b1;
      uniq_count++;
    end else begin
      r.full = 1'b1;
    end
    r.count = CNT_W'(uniq_count);
    return r;
  endfunction

  always @(posedge clk) begin
    vtx_t          v;
    dedup_result_t exp_r;
    if (!rst_n) begin
      awaited_indices.delete();
      uniq_count = 0;
      tolerance = TOL_RESET;
    end else begin
      if (cfg_we) tolerance = cfg_wdata;
      if (in_valid && !in_stall) begin
        v[ATTR_POS_X]  = in_pos_x;
        v[ATTR_POS_Y]  = in_pos_y;
        v[ATTR_POS_Z]  = in_pos_z;
        v[ATTR_NORM_X] = in_norm_x;
        v[ATTR_NORM_Y] = in_norm_y;
        v[ATTR_NORM_Z] = in_norm_z;
        v[ATTR_TEX_U]  = in_tex_u;
        v[ATTR_TEX_V]  = in_tex_v;
        exp_r = index_vertex(in_start_of_mesh, v);
        awaited_indices.insert(awaited_indices.size(), exp_r);
      end
      if (out_valid && !out_stall) begin
        if (awaited_indices.size() == 0) begin
          $error("unexpected result: match_index %0d", out_match_index);
          errors++;
        end else begin
          exp_r = awaited_indices.pop_front();
          if (out_match_index !== exp_r.index) begin
            $error("match_index: expected %0d, actual %0d", exp_r.index, out_match_index);
            errors++;
          end
          if (out_is_new !== exp_r.is_new) begin
            $error("is_new: expected %0d, actual %0d", exp_r.is_new, out_is_new);
            errors++;
          end
          if (out_table_full !== exp_r.full) begin
            $error("table_full: expected %0d, actual %0d", exp_r.full, out_table_full);
            errors++;
          end
          if (out_unique_count !== exp_r.count) begin
            $error("unique_count: expected %0d, actual %0d", exp_r.count, out_unique_count);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending <= awaited_indices.size();
  end

endmodule

/* bench/fuzzy_vertex_dedup_indexer_tb.sv */
// ----------------------------------------------------------------------------
// fuzzy_vertex_dedup_indexer_tb: stimulus and verdict for the dedup indexer
// Directed vertices around the tolerance boundary and the value extremes,
// then random meshes of near-duplicate vertices under several tolerances,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module fuzzy_vertex_dedup_indexer_tb;
  import fvdi_pkg::*;

  // A long receiver hold-off, and the number of cycles without any accepted
  // item that we tolerate before calling the run hung. A full-table miss
  // is the worst-case search, and the limit leaves a wide margin over the
  // hold-off plus one such search.
  localparam int HOLD_OFF    = 400;
  localparam int HANG_LIMIT  = 8000;
  localparam int TAIL_CYCLES = 40;
  localparam int SEGMENTS    = 4;
  localparam int SEG_ITEMS   = 140;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [TOL_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_start_of_mesh;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0] in_norm_x, in_norm_y, in_norm_z;
  logic signed [31:0] in_tex_u, in_tex_v;
  logic               out_valid;
  logic               out_stall;
  logic [9:0]         out_match_index;
  logic               out_is_new;
  logic               out_table_full;
  logic [10:0]        out_unique_count;

  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  int                 holds_asked;
  int                 holds_done;
  bit                 steady;
  logic [TOL_W-1:0]   cur_tol;
  vtx_t               mesh_vtx [$];

  always #5 clk = ~clk;

  fuzzy_vertex_dedup_indexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_of_mesh (in_start_of_mesh),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_norm_x        (in_norm_x),
    .in_norm_y        (in_norm_y),
    .in_norm_z        (in_norm_z),
    .in_tex_u         (in_tex_u),
    .in_tex_v         (in_tex_v),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_index  (out_match_index),
    .out_is_new       (out_is_new),
    .out_table_full   (out_table_full),
    .out_unique_count (out_unique_count)
  );

  fvdi_dedup_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_of_mesh (in_start_of_mesh),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_norm_x        (in_norm_x),
    .in_norm_y        (in_norm_y),
    .in_norm_z        (in_norm_z),
    .in_tex_u         (in_tex_u),
    .in_tex_v         (in_tex_v),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_index  (out_match_index),
    .out_is_new       (out_is_new),
    .out_table_full   (out_table_full),
    .out_unique_count (out_unique_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Hang detector: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side. Most stalls are short, a few are long, and now and then the
  // receiver runs free. A hold-off request from the stimulus keeps the stall
  // up long enough for the block to back up into its input channel while the
  // sender keeps offering items.
  initial begin
    int r;
    int stall_left;
    int flow_left;
    out_stall = 1'b0;
    stall_left = 0;
    flow_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (flow_left > 0) begin
          flow_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            flow_left = $urandom_range(50, 300);
          end else if (r < 40) begin
            r = $urandom_range(0, 99);
            if (r < 70) stall_left = $urandom_range(1, 2);
            else if (r < 95) stall_left = $urandom_range(3, 12);
            else stall_left = $urandom_range(40, 150);
          end
        end
      end
    end
  end

  // Gap after an accepted item; none at all while a steady burst is running.
  function automatic int sender_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Attribute values: full-range random, small values near zero that make
  // chance matches likely, and the corners of the signed range.
  function automatic vtx_t fresh_vertex();
    vtx_t v;
    int   r;
    for (int k = 0; k < ATTR_COUNT; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 3))
          0:       v[k] = 32'h8000_0000;
          1:       v[k] = 32'h7fff_ffff;
          2:       v[k] = 32'h0000_0000;
          default: v[k] = 32'hffff_ffff;
        endcase
      end else if (r < 5) begin
        v[k] = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
      end else begin
        v[k] = $urandom();
      end
    end
    return v;
  endfunction

  // Offset within the tolerance, picked with a random sign.
  function automatic int near_offset(int limit);
    int d;
    d = (limit <= 0) ? 0 : $urandom_range(0, limit - 1);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  // Moves a vertex by small offsets. Usually every attribute stays inside the
  // tolerance; sometimes one attribute lands just at or just inside the
  // boundary; otherwise the offsets may fall on either side.
  function automatic vtx_t nudge(vtx_t base);
    vtx_t v;
    int   mode;
    int   edge_k;
    int   d;
    int   tol;
    tol = int'(cur_tol);
    mode = $urandom_range(0, 99);
    edge_k = $urandom_range(0, ATTR_COUNT - 1);
    for (int k = 0; k < ATTR_COUNT; k++) begin
      if (mode < 60) begin
        d = near_offset(tol);
      end else if (mode < 80) begin
        if (k == edge_k) begin
          d = tol - $urandom_range(0, 1);
          if ($urandom_range(0, 1)) d = -d;
        end else begin
          d = near_offset(tol);
        end
      end else begin
        d = near_offset(2 * tol + 3);
      end
      v[k] = base[k] + 32'(d);
    end
    return v;
  endfunction

  // Most items revisit a vertex already sent in this mesh, either exactly or
  // slightly moved, so the search runs deep into the table.
  function automatic vtx_t pick_vertex();
    int   r;
    vtx_t base;
    r = $urandom_range(0, 99);
    if (mesh_vtx.size() == 0 || r < 30) return fresh_vertex();
    base = mesh_vtx[$urandom_range(0, mesh_vtx.size() - 1)];
    if (r < 45) return base;
    return nudge(base);
  endfunction

  function automatic vtx_t flat(logic [31:0] x);
    vtx_t v;
    v = {ATTR_COUNT{x}};
    return v;
  endfunction

  function automatic vtx_t one_attr(int k, logic [31:0] x);
    vtx_t v;
    v = '0;
    v[k] = x;
    return v;
  endfunction

  // Offers one vertex, holds it until the block takes it, then idles for a
  // random gap. Valid stays high into the next item when the gap is zero.
  task automatic offer(logic start, vtx_t v);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_start_of_mesh = start;
    in_pos_x  = v[ATTR_POS_X];
    in_pos_y  = v[ATTR_POS_Y];
    in_pos_z  = v[ATTR_POS_Z];
    in_norm_x = v[ATTR_NORM_X];
    in_norm_y = v[ATTR_NORM_Y];
    in_norm_z = v[ATTR_NORM_Z];
    in_tex_u  = v[ATTR_TEX_U];
    in_tex_v  = v[ATTR_TEX_V];
    do @(posedge clk); while (in_stall);
    if (start) mesh_vtx.delete();
    mesh_vtx.insert(mesh_vtx.size(), v);
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // The tolerance is only written with the block idle. Every item yields a
  // result, so once all results are in, nothing is left in flight.
  task automatic set_tolerance(logic [TOL_W-1:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = val;
    cur_tol = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int   mesh_len;
    int   sent;
    logic start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_start_of_mesh = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_norm_x = '0;
    in_norm_y = '0;
    in_norm_z = '0;
    in_tex_u = '0;
    in_tex_v = '0;
    holds_asked = 0;
    steady = 1'b0;
    cur_tol = TOL_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, first under the reset tolerance. Differences of 654
    // match, a difference of exactly 655 does not.
    offer(1'b1, flat(32'd0));
    offer(1'b0, flat(32'd654));
    offer(1'b0, flat(-32'sd654));
    offer(1'b0, one_attr(ATTR_POS_X, 32'd655));
    for (int k = 0; k < ATTR_COUNT; k++) offer(1'b0, one_attr(k, -32'sd655));
    // Opposite corners of the signed range are 2^32 - 1 apart.
    offer(1'b0, flat(32'h8000_0000));
    offer(1'b0, flat(32'h7fff_ffff));
    offer(1'b0, flat(32'h7fff_fd71));
    // A start of mesh in the middle empties the table.
    offer(1'b1, one_attr(ATTR_TEX_V, 32'h7fff_ffff));
    // With zero tolerance even an exact copy is new.
    set_tolerance('0);
    offer(1'b0, one_attr(ATTR_TEX_V, 32'h7fff_ffff));
    // Widest tolerance: 65534 apart matches, 65535 apart does not.
    set_tolerance('1);
    offer(1'b0, one_attr(ATTR_TEX_V, 32'h7fff_0001));
    offer(1'b0, one_attr(ATTR_TEX_V, 32'h7fff_0000));
    offer(1'b0, one_attr(ATTR_TEX_V, 32'h8000_0000));
    set_tolerance(TOL_W'(1));
    offer(1'b0, one_attr(ATTR_TEX_V, 32'h8000_0000));

    // Random meshes, one tolerance per segment. Each segment ends with the
    // sender waiting for every result before the tolerance changes.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       set_tolerance(TOL_W'($urandom_range(1, 16)));
        1:       set_tolerance(TOL_W'($urandom_range(0, 65535)));
        2:       set_tolerance(TOL_RESET);
        default: set_tolerance(TOL_W'($urandom_range(4096, 65535)));
      endcase
      sent = 0;
      while (sent < SEG_ITEMS) begin
        mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 30);
        steady = ($urandom_range(0, 4) == 0);
        for (int j = 0; j < mesh_len && sent < SEG_ITEMS; j++) begin
          // One long receiver hold-off while items keep coming.
          if (seg == 1 && sent == 40) holds_asked++;
          start = (j == 0) || ($urandom_range(0, 49) == 0);
          offer(start, pick_vertex());
          sent++;
        end
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
